[src/kdspm_pkg.sv]
// ----------------------------------------------------------------------------
// kdspm_pkg
// types and constants shared by the kd split position pipeline
// ----------------------------------------------------------------------------
package kdspm_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
   localparam int METRIC_W    = 32;
   localparam int GAP_WIDTH   = 32;

   // t holds 0 .. ONE inclusive
   localparam int T_WIDTH     = FRAC_BITS + 1;
   // sqrt of metric_len2 * ONE
   localparam int ROOT_IN_W   = METRIC_W + FRAC_BITS;
   localparam int ROOT_STAGES = ROOT_IN_W / 2;
   localparam int LEN_WIDTH   = ROOT_STAGES;
   localparam int TLEN_WIDTH  = LEN_WIDTH;
   // quotient of (t or u) * ONE / t_len
   localparam int QUO_WIDTH   = 2 * FRAC_BITS;
   localparam int PROD_WIDTH  = SIZE_WIDTH + T_WIDTH;

   localparam logic [GAP_WIDTH-1:0] GAP_RESET = GAP_WIDTH'(2) << FRAC_BITS;
   localparam logic [T_WIDTH-1:0]   Q_ONE     = T_WIDTH'(1) << FRAC_BITS;
   localparam logic [T_WIDTH-1:0]   Q_HALF    = T_WIDTH'(1) << (FRAC_BITS - 1);
   localparam logic [ROOT_IN_W-1:0] ROOT_TOP  = ROOT_IN_W'(1) << (ROOT_IN_W - 2);

   localparam logic [1:0] CASE_NEAR_START = 2'd0;
   localparam logic [1:0] CASE_NEAR_END   = 2'd1;
   localparam logic [1:0] CASE_SHIFT_LOW  = 2'd2;
   localparam logic [1:0] CASE_SHIFT_HIGH = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_origin_x;
      logic signed [COORD_WIDTH-1:0] box_origin_y;
      logic [SIZE_WIDTH-1:0]         box_size_x;
      logic [SIZE_WIDTH-1:0]         box_size_y;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic [METRIC_W-1:0]           metric_len2_x;
      logic [METRIC_W-1:0]           metric_len2_y;
   } req_type;

   typedef struct packed {
      logic                          cut_axis;
      logic signed [COORD_WIDTH-1:0] split_coordinate;
      logic [1:0]                    split_case;
      logic                          zero_size;
   } rsp_type;

   typedef struct packed {
      logic                   valid;
      logic                   axis;
      logic                   zero;
      logic [COORD_WIDTH-1:0] d0;
      logic [SIZE_WIDTH-1:0]  d10;
      logic [COORD_WIDTH:0]   diff;
      logic [METRIC_W-1:0]    m2;
   } select_type;

   typedef struct packed {
      logic                   valid;
      logic                   axis;
      logic                   zero;
      logic                   tzero;
      logic                   tone;
      logic [COORD_WIDTH-1:0] d0;
      logic [SIZE_WIDTH-1:0]  d10;
      logic [COORD_WIDTH-1:0] num;
      logic [FRAC_BITS-1:0]   q;
      logic [ROOT_IN_W-1:0]   n;
      logic [ROOT_IN_W-1:0]   r;
   } root_type;

   typedef struct packed {
      logic                   valid;
      logic                   axis;
      logic                   zero;
      logic [COORD_WIDTH-1:0] d0;
      logic [SIZE_WIDTH-1:0]  d10;
      logic [T_WIDTH-1:0]     t;
      logic [LEN_WIDTH-1:0]   len;
      logic [TLEN_WIDTH-1:0]  t_len;
   } tlen_type;

   typedef struct packed {
      logic                   valid;
      logic                   axis;
      logic                   zero;
      logic [COORD_WIDTH-1:0] d0;
      logic [SIZE_WIDTH-1:0]  d10;
      logic [T_WIDTH-1:0]     t;
      logic [1:0]             cas;
      logic [TLEN_WIDTH-1:0]  den;
      logic [QUO_WIDTH-1:0]   num;
      logic [TLEN_WIDTH-1:0]  rem;
      logic [QUO_WIDTH-1:0]   q;
   } quo_type;

   typedef struct packed {
      logic                   valid;
      logic                   axis;
      logic                   zero;
      logic [COORD_WIDTH-1:0] d0;
      logic [SIZE_WIDTH-1:0]  d10;
      logic [1:0]             cas;
      logic [T_WIDTH-1:0]     factor;
   } factor_type;

   typedef struct packed {
      logic                   valid;
      logic                   axis;
      logic                   zero;
      logic [COORD_WIDTH-1:0] d0;
      logic [1:0]             cas;
      logic [COORD_WIDTH-1:0] offset;
   } offset_type;

endpackage

[src/kd_split_position_metric_top.sv]
// ----------------------------------------------------------------------------
// kd_split_position_metric_top
// split axis and split position of a 2d box around a source point
// ----------------------------------------------------------------------------
// One item enters per cycle while no result waits at the output. It passes
// the axis select register, 24 stages that carry the square root one digit
// per stage (the position divide runs in the first 16 of them), the t * len
// and case compare registers, 32 stages of the restoring quotient divide,
// then factor, size scaling and the saturating add into the output
// register. The whole pipeline holds while a result waits at the output;
// gap writes take effect for items that reach the case compare afterwards.
module kd_split_position_metric_top
   import kdspm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [GAP_WIDTH-1:0] csr_write_data
);

   logic [GAP_WIDTH-1:0] gap_ff;
   logic                 advance;

   select_type a_ff, a_in;
   root_type   b_ff [ROOT_STAGES];
   root_type   b_in [ROOT_STAGES];
   root_type   b_src [ROOT_STAGES];
   tlen_type   c_ff, c_in;
   quo_type    d_ff, d_in;
   quo_type    e_ff [QUO_WIDTH];
   quo_type    e_in [QUO_WIDTH];
   quo_type    e_src [QUO_WIDTH];
   factor_type f_ff, f_in;
   offset_type g_ff, g_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // axis select
   always_comb begin
      logic [COORD_WIDTH-1:0] dp;
      a_in.valid = req_valid;
      a_in.axis  = !(req_data.metric_len2_x > req_data.metric_len2_y);
      a_in.d0    = a_in.axis ? req_data.box_origin_y : req_data.box_origin_x;
      a_in.d10   = a_in.axis ? req_data.box_size_y : req_data.box_size_x;
      dp         = a_in.axis ? req_data.point_y : req_data.point_x;
      a_in.m2    = a_in.axis ? req_data.metric_len2_y : req_data.metric_len2_x;
      a_in.zero  = (a_in.d10 == '0);
      a_in.diff  = {dp[COORD_WIDTH-1], dp} - {a_in.d0[COORD_WIDTH-1], a_in.d0};
   end

   // square root and position divide, one digit per stage
   always_comb begin
      logic [ROOT_IN_W-1:0]   bitv;
      logic [ROOT_IN_W-1:0]   trial;
      logic [COORD_WIDTH-1:0] sh;
      b_src[0].valid = a_ff.valid;
      b_src[0].axis  = a_ff.axis;
      b_src[0].zero  = a_ff.zero;
      b_src[0].tzero = a_ff.zero || a_ff.diff[COORD_WIDTH] || (a_ff.diff == '0);
      b_src[0].tone  = !a_ff.diff[COORD_WIDTH]
                       && (a_ff.diff >= {2'b00, a_ff.d10});
      b_src[0].d0    = a_ff.d0;
      b_src[0].d10   = a_ff.d10;
      b_src[0].num   = a_ff.diff[COORD_WIDTH-1:0];
      b_src[0].q     = '0;
      b_src[0].n     = {a_ff.m2, {FRAC_BITS{1'b0}}};
      b_src[0].r     = '0;
      for (int k = 1; k < ROOT_STAGES; k++) begin
         b_src[k] = b_ff[k-1];
      end
      for (int k = 0; k < ROOT_STAGES; k++) begin
         b_in[k] = b_src[k];
         bitv    = ROOT_TOP >> (2 * k);
         trial   = b_src[k].r + bitv;
         if (b_src[k].n >= trial) begin
            b_in[k].n = b_src[k].n - trial;
            b_in[k].r = (b_src[k].r >> 1) + bitv;
         end else begin
            b_in[k].r = b_src[k].r >> 1;
         end
         if (k < FRAC_BITS) begin
            sh = {b_src[k].num[COORD_WIDTH-2:0], 1'b0};
            if (sh >= {1'b0, b_src[k].d10}) begin
               b_in[k].num = sh - {1'b0, b_src[k].d10};
               b_in[k].q   = {b_src[k].q[FRAC_BITS-2:0], 1'b1};
            end else begin
               b_in[k].num = sh;
               b_in[k].q   = {b_src[k].q[FRAC_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // t and t * len
   always_comb begin
      logic [T_WIDTH+LEN_WIDTH-1:0] prod;
      c_in.valid = b_ff[ROOT_STAGES-1].valid;
      c_in.axis  = b_ff[ROOT_STAGES-1].axis;
      c_in.zero  = b_ff[ROOT_STAGES-1].zero;
      c_in.d0    = b_ff[ROOT_STAGES-1].d0;
      c_in.d10   = b_ff[ROOT_STAGES-1].d10;
      if (b_ff[ROOT_STAGES-1].tzero) begin
         c_in.t = '0;
      end else if (b_ff[ROOT_STAGES-1].tone) begin
         c_in.t = Q_ONE;
      end else begin
         c_in.t = {1'b0, b_ff[ROOT_STAGES-1].q};
      end
      c_in.len   = b_ff[ROOT_STAGES-1].r[LEN_WIDTH-1:0];
      prod       = c_in.t * c_in.len;
      c_in.t_len = prod[FRAC_BITS +: TLEN_WIDTH];
   end

   // case select
   always_comb begin
      logic [LEN_WIDTH-1:0] rest;
      logic [T_WIDTH-1:0]   u;
      rest       = c_ff.len - c_ff.t_len;
      u          = Q_ONE - c_ff.t;
      d_in.valid = c_ff.valid;
      d_in.axis  = c_ff.axis;
      d_in.zero  = c_ff.zero;
      d_in.d0    = c_ff.d0;
      d_in.d10   = c_ff.d10;
      d_in.t     = c_ff.t;
      d_in.den   = c_ff.t_len;
      d_in.rem   = '0;
      d_in.q     = '0;
      if (GAP_WIDTH'(c_ff.t_len) <= gap_ff) begin
         d_in.cas = CASE_NEAR_START;
         d_in.num = '0;
      end else if (GAP_WIDTH'(rest) <= gap_ff) begin
         d_in.cas = CASE_NEAR_END;
         d_in.num = '0;
      end else if (c_ff.t < Q_HALF) begin
         d_in.cas = CASE_SHIFT_LOW;
         d_in.num = {c_ff.t[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      end else begin
         d_in.cas = CASE_SHIFT_HIGH;
         d_in.num = QUO_WIDTH'(u) << FRAC_BITS;
      end
   end

   // restoring divide by t_len, one quotient bit per stage
   always_comb begin
      logic [TLEN_WIDTH:0] sh;
      e_src[0] = d_ff;
      for (int k = 1; k < QUO_WIDTH; k++) begin
         e_src[k] = e_ff[k-1];
      end
      for (int k = 0; k < QUO_WIDTH; k++) begin
         e_in[k]     = e_src[k];
         sh          = {e_src[k].rem, e_src[k].num[QUO_WIDTH-1]};
         e_in[k].num = {e_src[k].num[QUO_WIDTH-2:0], 1'b0};
         if (sh >= {1'b0, e_src[k].den}) begin
            e_in[k].rem = TLEN_WIDTH'(sh - {1'b0, e_src[k].den});
            e_in[k].q   = {e_src[k].q[QUO_WIDTH-2:0], 1'b1};
         end else begin
            e_in[k].rem = sh[TLEN_WIDTH-1:0];
            e_in[k].q   = {e_src[k].q[QUO_WIDTH-2:0], 1'b0};
         end
      end
   end

   // split factor
   always_comb begin
      quo_type             e;
      logic [QUO_WIDTH:0]  sum;
      e          = e_ff[QUO_WIDTH-1];
      sum        = (QUO_WIDTH+1)'(e.t) + {1'b0, e.q};
      f_in.valid = e.valid;
      f_in.axis  = e.axis;
      f_in.zero  = e.zero;
      f_in.d0    = e.d0;
      f_in.d10   = e.d10;
      f_in.cas   = e.cas;
      case (e.cas)
         CASE_NEAR_START: f_in.factor = e.t;
         CASE_NEAR_END:   f_in.factor = Q_ONE - e.t;
         CASE_SHIFT_LOW: begin
            if (e.q >= QUO_WIDTH'(e.t)) begin
               f_in.factor = '0;
            end else begin
               f_in.factor = e.t - e.q[T_WIDTH-1:0];
            end
         end
         CASE_SHIFT_HIGH: begin
            if (sum > (QUO_WIDTH+1)'(Q_ONE)) begin
               f_in.factor = Q_ONE;
            end else begin
               f_in.factor = sum[T_WIDTH-1:0];
            end
         end
         default: f_in.factor = e.t;
      endcase
   end

   // size scaling
   always_comb begin
      logic [PROD_WIDTH-1:0] prod;
      prod        = f_ff.d10 * f_ff.factor;
      g_in.valid  = f_ff.valid;
      g_in.axis   = f_ff.axis;
      g_in.zero   = f_ff.zero;
      g_in.d0     = f_ff.d0;
      g_in.cas    = f_ff.cas;
      g_in.offset = prod[FRAC_BITS +: COORD_WIDTH];
   end

   // saturating add onto the origin
   always_comb begin
      logic signed [COORD_WIDTH+1:0] res;
      logic signed [COORD_WIDTH+1:0] hi;
      logic signed [COORD_WIDTH+1:0] lo;
      res = $signed({{2{g_ff.d0[COORD_WIDTH-1]}}, g_ff.d0})
            + $signed({2'b00, g_ff.offset});
      hi  = (COORD_WIDTH+2)'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
      lo  = -hi - (COORD_WIDTH+2)'(1);
      out_valid_in           = g_ff.valid;
      out_data_in.cut_axis   = g_ff.axis;
      out_data_in.split_case = g_ff.cas;
      out_data_in.zero_size  = g_ff.zero;
      if (res > hi) begin
         out_data_in.split_coordinate = hi[COORD_WIDTH-1:0];
      end else if (res < lo) begin
         out_data_in.split_coordinate = lo[COORD_WIDTH-1:0];
      end else begin
         out_data_in.split_coordinate = res[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else if (csr_write_enable) begin
         gap_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         for (int k = 0; k < ROOT_STAGES; k++) begin
            b_ff[k].valid <= 1'b0;
         end
         c_ff.valid <= 1'b0;
         d_ff.valid <= 1'b0;
         for (int k = 0; k < QUO_WIDTH; k++) begin
            e_ff[k].valid <= 1'b0;
         end
         f_ff.valid   <= 1'b0;
         g_ff.valid   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_ff <= a_in;
         for (int k = 0; k < ROOT_STAGES; k++) begin
            b_ff[k] <= b_in[k];
         end
         c_ff <= c_in;
         d_ff <= d_in;
         for (int k = 0; k < QUO_WIDTH; k++) begin
            e_ff[k] <= e_in[k];
         end
         f_ff         <= f_in;
         g_ff         <= g_in;
         out_valid_ff <= out_valid_in;
         out_data_ff  <= out_data_in;
      end
   end

endmodule

[verif/tb_kd_split_position_metric_top.sv]
// ----------------------------------------------------------------------------
// tb_kd_split_position_metric_top
// directed table and random items through the kd split pipeline, each result
// checked against a local predictor of axis, t, metric length and split case
// ----------------------------------------------------------------------------
module tb_kd_split_position_metric_top;
   import kdspm_pkg::*;

   localparam int LATENCY   = 62;
   localparam int N_RANDOM  = 1830;
   localparam longint LIMIT = 400000;

   typedef struct {
      req_type item;
      logic    has_result;
      rsp_type result;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_write_enable;
   logic [GAP_WIDTH-1:0] csr_write_data;

   logic [31:0]  metric_gap;
   rsp_type      pending_splits[$];
   int           error_count;
   longint       cycle_count;
   logic         quiet_tail;
   logic         hold_off_req;
   stim_row_type directed_rows[$];

   kd_split_position_metric_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic rsp_type predict_split(input req_type it, input logic [31:0] gap);
      rsp_type     o;
      logic        axis;
      longint      org;
      longint      pnt;
      longint      res;
      logic [63:0] sz;
      logic [63:0] m2;
      logic [63:0] t;
      logic [63:0] len;
      logic [63:0] tl;
      logic [63:0] fac;
      logic [63:0] q;
      logic [63:0] u;
      logic [63:0] diff;
      logic [63:0] one;
      logic [1:0]  cas;
      one  = 64'd1 << FRAC_BITS;
      axis = (it.metric_len2_x > it.metric_len2_y) ? 1'b0 : 1'b1;
      org  = axis ? longint'(it.box_origin_y) : longint'(it.box_origin_x);
      pnt  = axis ? longint'(it.point_y) : longint'(it.point_x);
      sz   = axis ? 64'(it.box_size_y) : 64'(it.box_size_x);
      m2   = axis ? 64'(it.metric_len2_y) : 64'(it.metric_len2_x);
      if (sz == 0 || pnt <= org) begin
         t = 0;
      end else begin
         diff = 64'(pnt - org);
         t = (diff >= sz) ? one : (diff << FRAC_BITS) / sz;
      end
      len = int_sqrt(m2 << FRAC_BITS);
      tl  = (t * len) >> FRAC_BITS;
      if (tl <= 64'(gap)) begin
         cas = CASE_NEAR_START;
         fac = t;
      end else if (len - tl <= 64'(gap)) begin
         cas = CASE_NEAR_END;
         fac = one - t;
      end else if (t < (one >> 1)) begin
         cas = CASE_SHIFT_LOW;
         q   = (t << FRAC_BITS) / tl;
         fac = (q >= t) ? 0 : t - q;
      end else begin
         cas = CASE_SHIFT_HIGH;
         u   = one - t;
         q   = (u << FRAC_BITS) / tl;
         fac = one - u + q;
      end
      if (fac > one) fac = one;
      res = org + longint'((sz * fac) >> FRAC_BITS);
      if (res > 64'sh7fffffff) res = 64'sh7fffffff;
      if (res < -64'sh80000000) res = -64'sh80000000;
      o.cut_axis         = axis;
      o.split_coordinate = res[31:0];
      o.split_case       = cas;
      o.zero_size        = (sz == 0);
      return o;
   endfunction

   // the receiver: random stalls, one long hold-off, none near the end
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 4);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_splits.size() == 0) begin
            $display("%0t unexpected result: actual %p", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type want;
            want = pending_splits.pop_front();
            if (rsp_data.cut_axis !== want.cut_axis)
               $display("%0t cut_axis: expected %0d actual %0d", $time,
                        want.cut_axis, rsp_data.cut_axis);
            if (rsp_data.split_coordinate !== want.split_coordinate)
               $display("%0t split_coordinate: expected %0h actual %0h", $time,
                        want.split_coordinate, rsp_data.split_coordinate);
            if (rsp_data.split_case !== want.split_case)
               $display("%0t split_case: expected %0d actual %0d", $time,
                        want.split_case, rsp_data.split_case);
            if (rsp_data.zero_size !== want.zero_size)
               $display("%0t zero_size: expected %0d actual %0d", $time,
                        want.zero_size, rsp_data.zero_size);
            if (rsp_data !== want) error_count++;
         end
      end
   end

   // valid stays up after an accept; the next item, an idle gap or the caller drops it
   task automatic send_item(input req_type it, input logic has_result, input rsp_type result);
      rsp_type want;
      want = predict_split(it, metric_gap);
      if (has_result && result !== want) begin
         $display("%0t table row: expected %p actual %p", $time, result, want);
         error_count++;
      end
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_splits.push_back(want);
   endtask

   task automatic write_gap(input logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_splits.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      metric_gap = value;
   endtask

   function automatic req_type random_item(input logic in_range);
      req_type      it;
      logic [255:0] raw;
      logic [31:0]  sx;
      logic [31:0]  sy;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      it  = raw[$bits(req_type)-1:0];
      if (in_range) begin
         // small boxes with the point inside or just past the end so every case is reached
         sx = $urandom_range(0, 8) == 0 ? 0 : $urandom_range(1, 32'h00400000);
         sy = $urandom_range(0, 8) == 0 ? 0 : $urandom_range(1, 32'h00400000);
         it.box_size_x    = sx[30:0];
         it.box_size_y    = sy[30:0];
         it.box_origin_x  = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
         it.box_origin_y  = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
         it.point_x       = it.box_origin_x + $signed($urandom_range(0, sx + 2));
         it.point_y       = it.box_origin_y + $signed($urandom_range(0, sy + 2));
         it.metric_len2_x = $urandom_range(0, 32'h06000000);
         it.metric_len2_y = ($urandom_range(0, 9) == 0) ? it.metric_len2_x
                                                        : $urandom_range(0, 32'h06000000);
      end
      return it;
   endfunction

   function automatic req_type make_item(input logic [31:0] ox, input logic [31:0] sx,
                                         input logic [31:0] px, input logic [31:0] mx,
                                         input logic [31:0] my);
      req_type it;
      it = '0;
      it.box_origin_x  = ox;
      it.box_origin_y  = ox;
      it.box_size_x    = sx[30:0];
      it.box_size_y    = sx[30:0];
      it.point_x       = px;
      it.point_y       = px;
      it.metric_len2_x = mx;
      it.metric_len2_y = my;
      return it;
   endfunction

   task automatic add_row(input req_type it, input logic has_result, input rsp_type result);
      stim_row_type row;
      row.item       = it;
      row.has_result = has_result;
      row.result     = result;
      directed_rows.push_back(row);
   endtask

   initial begin
      rsp_type none;
      none             = '0;
      error_count      = 0;
      cycle_count      = 0;
      quiet_tail       = 1'b0;
      hold_off_req     = 1'b0;
      metric_gap       = GAP_RESET;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;

      // zero size on y at a tie: case near start at origin
      add_row(make_item(32'h00010000, 0, 32'h00050000, 5, 5), 1'b1,
              '{1'b1, 32'h00010000, CASE_NEAR_START, 1'b1});
      // zero size on x at the extreme origin
      add_row(make_item(32'h80000000, 0, 32'h7fffffff, 9, 1), 1'b1,
              '{1'b0, 32'h80000000, CASE_NEAR_START, 1'b1});
      // point below the box, zero metric
      add_row(make_item(32'h00100000, 32'h00100000, 32'h00000000, 0, 0), 1'b1,
              '{1'b1, 32'h00100000, CASE_NEAR_START, 1'b0});
      add_row(make_item(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0), 1'b0, none);
      add_row(make_item(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff),
              1'b0, none);
      add_row(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 32'hffffffff), 1'b0, none);
      add_row(make_item(32'h00000000, 32'h00100000, 32'h00020000, 32'h00640000, 0), 1'b0, none);
      add_row(make_item(32'h00000000, 32'h00100000, 32'h000e0000, 32'h00640000, 0), 1'b0, none);
      add_row(make_item(32'h00000000, 32'h00100000, 32'h00070000, 32'h00640000, 0), 1'b0, none);
      add_row(make_item(32'h00000000, 32'h00100000, 32'h00090000, 32'h00640000, 0), 1'b0, none);
      add_row(make_item(32'hfff00000, 32'h00100000, 32'hfff80000, 32'h04000000, 32'h04000000),
              1'b0, none);
      add_row(make_item(32'h00000000, 32'h00000001, 32'h00000001, 32'h01000000, 0), 1'b0, none);
      add_row(make_item(32'h7fff0000, 32'h7fffffff, 32'h7fffff00, 32'h00640000, 0), 1'b0, none);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].has_result,
                   directed_rows[i].result);

      // several gap settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_gap(32'd0);
            1: write_gap(32'hffffffff);
            2: write_gap(32'h00008000);
            3: write_gap($urandom_range(0, 32'h00100000));
            4: write_gap(GAP_RESET);
            default: write_gap(32'h00010000);
         endcase
         if (phase == 4) hold_off_req = 1'b1;
         if (phase == 5) quiet_tail = 1'b1;
         for (int n = 0; n < N_RANDOM / 6; n++)
            send_item(random_item($urandom_range(0, 9) != 0), 1'b0, none);
      end

      req_valid <= 1'b0;
      while (pending_splits.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
